/* hw/rtl/swp_pkg.sv */
// ----------------------------------------------------------------------------
// swp_pkg
// Shared constants and types for the stereo width panner.
// ----------------------------------------------------------------------------
`default_nettype none

package swp_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF      = 24;
  localparam int ANGLE_BITS_DEF       = 12;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // fixed field and gain formats
  localparam int SPREAD_BITS  = 11;
  localparam int SPREAD_SHIFT = 13;
  localparam int GAIN_FRAC    = 23;            // Q.23, 1.0 = 2^23
  localparam int GAIN_W       = GAIN_FRAC + 2; // signed, holds +/-1.0

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int              COMP_DEPTH  = 3388998;     // 0.404 in Q.23

  typedef logic signed [GAIN_W-1:0] gain_t;

  // clock enables of a module that owns two pipeline stages
  typedef struct packed {
    logic en_a;
    logic en_b;
  } pair_en_t;

endpackage

`default_nettype wire

/* hw/rtl/swp_in_if.sv */
// ----------------------------------------------------------------------------
// swp_in_if
// Input request channel: one stereo sample pair with azimuth and width.
// ----------------------------------------------------------------------------
`default_nettype none

interface swp_in_if #(
  parameter int SAMPLE_BITS = swp_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = swp_pkg::ANGLE_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [SAMPLE_BITS-1:0]       left_in;
  logic signed [SAMPLE_BITS-1:0]       right_in;
  logic [ANGLE_BITS-1:0]               azimuth;
  logic [swp_pkg::SPREAD_BITS-1:0]     spread;

  modport source (output valid, left_in, right_in, azimuth, spread, input ready);
  modport sink   (input valid, left_in, right_in, azimuth, spread, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swp_out_if.sv */
// ----------------------------------------------------------------------------
// swp_out_if
// Result request channel: one panned stereo sample pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface swp_out_if #(
  parameter int SAMPLE_BITS = swp_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stereo_width_panner_core.sv */
// ----------------------------------------------------------------------------
// stereo_width_panner_core
// Constant-power stereo width panner, seven-stage pipeline.
// ----------------------------------------------------------------------------
//
//   port     dir   role     payload
//   in_ch    in    sink     left_in, right_in, azimuth, spread
//   out_ch   out   source   left_out, right_out
//
// One sample pair per cycle unless back-pressure from the output fills the
// pipeline; a request passes through the stages in order (table lookup, positions,
// five parallel table lookups, compensation, gain scaling, products, sum).
// The sine table is replicated, one ROM port per lookup, six in all.
// Reset clears the stage valid bits only; data registers are not reset.
// Ready ripples back stage by stage, so empty stages keep filling while the
// output register waits; a held stage keeps its request intact.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_width_panner_core #(
  parameter int SAMPLE_BITS      = swp_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS       = swp_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = swp_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swp_in_if.sink     in_ch,
  swp_out_if.source  out_ch
);

  localparam int GF     = swp_pkg::GAIN_FRAC;
  localparam int GW     = swp_pkg::GAIN_W;
  localparam int POS_W  = GW + 2;                 // pan +/- width headroom
  localparam int PHW    = ANGLE_BITS + GF + 1;    // position to phase
  localparam int CHW    = ANGLE_BITS + GF;        // |pan| to phase

  // pipeline stages
  localparam int NSTAGE   = 7;
  localparam int S_LOOKUP = 0;
  localparam int S_POS    = 1;
  localparam int S_TRIG   = 2;
  localparam int S_COMP   = 3;
  localparam int S_GAIN   = 4;
  localparam int S_PROD   = 5;
  localparam int S_OUT    = 6;

  // lanes of the parallel lookup
  localparam int NLANE   = 5;
  localparam int LANE_CL = 0;   // cos, left source
  localparam int LANE_SL = 1;   // sin, left source
  localparam int LANE_CR = 2;   // cos, right source
  localparam int LANE_SR = 3;   // sin, right source
  localparam int LANE_CV = 4;   // cos, compensation curve

  localparam logic [ANGLE_BITS-1:0] QTR  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic signed [POS_W-1:0] PONE = POS_W'(1) <<< GF;
  localparam logic signed [POS_W-1:0] MONE = -PONE;

  function automatic logic signed [POS_W-1:0] clamp_unit(input logic signed [POS_W-1:0] v);
    if (v < MONE) begin
      return MONE;
    end else if (v > PONE) begin
      return PONE;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // stage control: valid bit per stage, enable when the stage is empty or
  // the next one moves
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ch.ready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[S_LOOKUP]) begin
      v_nxt[S_LOOKUP] = in_ch.valid;
    end
    for (int s = 1; s < NSTAGE; s++) begin
      if (en[s]) begin
        v_nxt[s] = v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en[S_LOOKUP];
  assign out_ch.valid = v_r[S_OUT];

  // --------------------------------------------------------------------------
  // stage 0: sin(azimuth) lookup, samples and width captured
  // --------------------------------------------------------------------------
  swp_pkg::gain_t                   pan_sin;
  logic signed [SAMPLE_BITS-1:0]    l0_r, r0_r;
  logic [swp_pkg::SPREAD_BITS-1:0]  spread0_r;

  swp_sine_rom #(
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom_pan (
    .clk   (clk),
    .en    (en[S_LOOKUP]),
    .phase (in_ch.azimuth),
    .value (pan_sin)
  );

  always_ff @(posedge clk) begin
    if (en[S_LOOKUP]) begin
      l0_r      <= in_ch.left_in;
      r0_r      <= in_ch.right_in;
      spread0_r <= in_ch.spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pan = -sin, source positions, phases for the five lookups
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0]       pan_w, spread_w, pl_c, pr_c, pan_abs;
  logic signed [POS_W-1:0]       ul_w, ur_w;
  logic [PHW-1:0]                phl_full, phr_full;
  logic [CHW-1:0]                cph_full;
  logic [ANGLE_BITS-1:0]         phl, phr, cph;
  logic [ANGLE_BITS-1:0]         ph_nxt [NLANE];
  logic [ANGLE_BITS-1:0]         ph_r   [NLANE];
  logic signed [SAMPLE_BITS-1:0] l1_r, r1_r;

  always_comb begin
    pan_w    = -POS_W'(pan_sin);
    spread_w = $signed({{(POS_W-swp_pkg::SPREAD_BITS-swp_pkg::SPREAD_SHIFT){1'b0}},
                        spread0_r, {swp_pkg::SPREAD_SHIFT{1'b0}}});
    pl_c     = clamp_unit(pan_w - spread_w);
    pr_c     = clamp_unit(pan_w + spread_w);
    ul_w     = pl_c + PONE;
    ur_w     = pr_c + PONE;
    // phase = ((p + 1) * quarter + half) >> 24, never above a quarter turn
    phl_full = (PHW'(ul_w[GW-1:0]) << (ANGLE_BITS - 2)) + (PHW'(1) << GF);
    phr_full = (PHW'(ur_w[GW-1:0]) << (ANGLE_BITS - 2)) + (PHW'(1) << GF);
    phl      = phl_full[GF+1 +: ANGLE_BITS];
    phr      = phr_full[GF+1 +: ANGLE_BITS];
    pan_abs  = (pan_w < 0) ? -pan_w : pan_w;
    cph_full = (CHW'(pan_abs[GF:0]) << (ANGLE_BITS - 2)) + (CHW'(1) << (GF - 1));
    cph      = cph_full[GF +: ANGLE_BITS];
    // cosine is the sine a quarter turn on
    ph_nxt[LANE_CL] = phl + QTR;
    ph_nxt[LANE_SL] = phl;
    ph_nxt[LANE_CR] = phr + QTR;
    ph_nxt[LANE_SR] = phr;
    ph_nxt[LANE_CV] = cph + QTR;
  end

  always_ff @(posedge clk) begin
    if (en[S_POS]) begin
      ph_r <= ph_nxt;
      l1_r <= l0_r;
      r1_r <= r0_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: five lookups in parallel
  // --------------------------------------------------------------------------
  swp_pkg::gain_t                rom_val [NLANE];
  logic signed [SAMPLE_BITS-1:0] l2_r, r2_r;

  for (genvar g = 0; g < NLANE; g++) begin : g_trig
    swp_sine_rom #(
      .ANGLE_BITS       (ANGLE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
      .clk   (clk),
      .en    (en[S_TRIG]),
      .phase (ph_r[g]),
      .value (rom_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[S_TRIG]) begin
      l2_r <= l1_r;
      r2_r <= r1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stages 3 and 4: compensation and gain scaling
  // --------------------------------------------------------------------------
  swp_pkg::gain_t                gain_raw [4];
  swp_pkg::gain_t                gain_fin [4];
  swp_pkg::pair_en_t             gs_en;
  logic signed [SAMPLE_BITS-1:0] l3_r, r3_r, l4_r, r4_r;

  assign gain_raw[0] = rom_val[LANE_CL];   // left source to left
  assign gain_raw[1] = rom_val[LANE_SL];   // left source to right
  assign gain_raw[2] = rom_val[LANE_CR];   // right source to left
  assign gain_raw[3] = rom_val[LANE_SR];   // right source to right
  assign gs_en.en_a  = en[S_COMP];
  assign gs_en.en_b  = en[S_GAIN];

  swp_gain_scale u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (gs_en),
    .valid_a  (v_r[S_COMP]),
    .curve    (rom_val[LANE_CV]),
    .gain_raw (gain_raw),
    .gain_o   (gain_fin)
  );

  always_ff @(posedge clk) begin
    if (en[S_COMP]) begin
      l3_r <= l2_r;
      r3_r <= r2_r;
    end
    if (en[S_GAIN]) begin
      l4_r <= l3_r;
      r4_r <= r3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stages 5 and 6: mix products, sum, saturate, output register
  // --------------------------------------------------------------------------
  swp_pkg::pair_en_t mx_en;

  assign mx_en.en_a = en[S_PROD];
  assign mx_en.en_b = en[S_OUT];

  swp_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk       (clk),
    .ctl       (mx_en),
    .l_in      (l4_r),
    .r_in      (r4_r),
    .gain      (gain_fin),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out)
  );

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[S_LOOKUP])
    else $error("accepted request missing from first stage");

  a_phase_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_POS] |-> (ph_r[LANE_SL] <= QTR && ph_r[LANE_SR] <= QTR))
    else $error("source phase beyond a quarter turn");

  a_gain_sign: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_TRIG] |-> (rom_val[LANE_CL] >= 0 && rom_val[LANE_SL] >= 0 &&
                     rom_val[LANE_CR] >= 0 && rom_val[LANE_SR] >= 0 &&
                     rom_val[LANE_CV] >= 0))
    else $error("negative constant-power gain");

endmodule

`default_nettype wire

/* hw/rtl/swp_sine_rom.sv */
// ----------------------------------------------------------------------------
// swp_sine_rom
// Sine of a phase from a quarter-wave ROM, registered read, one port.
// ----------------------------------------------------------------------------
`default_nettype none

module swp_sine_rom #(
  parameter int ANGLE_BITS       = swp_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = swp_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] phase,
  output swp_pkg::gain_t             value
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int R_W    = ANGLE_BITS - 1;
  localparam int PROD_W = R_W + IDX_W;
  localparam int ENT_W  = swp_pkg::GAIN_FRAC + 1;

  typedef logic [ENT_W-1:0] tab_entry_t;
  typedef tab_entry_t tab_arr_t [SINE_TABLE_DEPTH+1];

  // quotient by shift and subtract; only evaluated while the table is built
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series in Q.30 up to x^13, rounded to Q.23
  function automatic tab_arr_t build_tab();
    tab_arr_t        t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint          sum;
    longint          v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = div_u64(swp_pkg::HALF_PI_Q30 * 64'(i), 64'(SINE_TABLE_DEPTH));
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        dv   = 64'((2 * k) * (2 * k + 1));
        term = div_u64((term * x2) >> 30, dv);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64) >>> 7;
      if (v > (64'sd1 <<< swp_pkg::GAIN_FRAC)) begin
        v = 64'sd1 <<< swp_pkg::GAIN_FRAC;
      end
      t[i] = v[ENT_W-1:0];
    end
    return t;
  endfunction

  localparam tab_arr_t SINE_TAB = build_tab();
  localparam logic [R_W-1:0] QTR_R = {1'b1, {(R_W-1){1'b0}}};

  logic [1:0]        quad;
  logic [R_W-1:0]    r_m;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;
  tab_entry_t        data_r;
  logic              neg_r;

  // odd quadrants run the table backwards, the lower half-turn negates
  always_comb begin
    quad = phase[ANGLE_BITS-1 -: 2];
    r_m  = {1'b0, phase[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      r_m = QTR_R - r_m;
    end
    prod = PROD_W'(r_m) * PROD_W'(SINE_TABLE_DEPTH);
    idx  = IDX_W'(prod >> (ANGLE_BITS - 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= SINE_TAB[idx];
      neg_r  <= quad[1];
    end
  end

  assign value = neg_r ? -$signed({1'b0, data_r}) : $signed({1'b0, data_r});

endmodule

`default_nettype wire

/* hw/rtl/swp_gain_scale.sv */
// ----------------------------------------------------------------------------
// swp_gain_scale
// Centre compensation from the curve, then scaling of the four gains.
// ----------------------------------------------------------------------------
`default_nettype none

module swp_gain_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swp_pkg::pair_en_t ctl,
  input  wire logic              valid_a,
  input  wire swp_pkg::gain_t    curve,
  input  wire swp_pkg::gain_t    gain_raw [4],
  output swp_pkg::gain_t         gain_o   [4]
);

  localparam int GW  = swp_pkg::GAIN_W;
  localparam int GF  = swp_pkg::GAIN_FRAC;
  localparam int CPW = 2 * GW - 2;      // curve times 0.404
  localparam int GPW = 2 * GW;          // gain times compensation

  localparam logic signed [CPW-1:0] DEPTH_C  = CPW'(swp_pkg::COMP_DEPTH);
  localparam logic signed [CPW-1:0] HALF_CP  = CPW'(1) <<< (GF - 1);
  localparam logic signed [GPW-1:0] HALF_GP  = GPW'(1) <<< (GF - 1);
  localparam swp_pkg::gain_t        GONE     = GW'(1) <<< GF;
  localparam swp_pkg::gain_t        COMP_MIN = GW'((1 << GF) - swp_pkg::COMP_DEPTH);

  logic signed [CPW-1:0] cp;
  logic signed [CPW-1:0] cp_rnd;
  swp_pkg::gain_t        comp_nxt;
  swp_pkg::gain_t        comp_r;
  swp_pkg::gain_t        raw_r  [4];
  logic signed [GPW-1:0] gp     [4];
  swp_pkg::gain_t        gain_r [4];

  // stage a: comp = 1 - round(0.404 * curve)
  always_comb begin
    cp       = CPW'(curve) * DEPTH_C;
    cp_rnd   = cp + HALF_CP;
    comp_nxt = GONE - $signed(cp_rnd[GF +: GW]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      comp_r <= comp_nxt;
      raw_r  <= gain_raw;
    end
  end

  // stage b: four parallel gain products, rounded back to Q.23
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gp[i] = GPW'(raw_r[i]) * GPW'(comp_r) + HALF_GP;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      for (int i = 0; i < 4; i++) begin
        gain_r[i] <= $signed(gp[i][GF +: GW]);
      end
    end
  end

  assign gain_o = gain_r;

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_a |-> (comp_r >= COMP_MIN && comp_r <= GONE))
    else $error("centre compensation out of range");

endmodule

`default_nettype wire

/* hw/rtl/swp_mix.sv */
// ----------------------------------------------------------------------------
// swp_mix
// 2x2 mix of the input pair with the scaled gains, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module swp_mix #(
  parameter int SAMPLE_BITS = swp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire swp_pkg::pair_en_t           ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] l_in,
  input  wire logic signed [SAMPLE_BITS-1:0] r_in,
  input  wire swp_pkg::gain_t              gain [4],
  output logic signed [SAMPLE_BITS-1:0]    left_out,
  output logic signed [SAMPLE_BITS-1:0]    right_out
);

  localparam int GF = swp_pkg::GAIN_FRAC;
  localparam int PW = SAMPLE_BITS + swp_pkg::GAIN_W;
  localparam int SW = PW + 1;
  localparam int RW = SW - GF;

  localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (GF - 1);
  localparam logic signed [RW-1:0] SMAX   = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN   = {{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [RW-1:0] v);
    if (v > SMAX) begin
      return SMAX[SAMPLE_BITS-1:0];
    end else if (v < SMIN) begin
      return SMIN[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  logic signed [PW-1:0]          prod_r [4];
  logic signed [SW-1:0]          sum_l;
  logic signed [SW-1:0]          sum_r;
  logic signed [SAMPLE_BITS-1:0] out_l_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r;
  logic signed [SAMPLE_BITS-1:0] out_r_r;

  // gain order: LL, LR, RL, RR
  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      prod_r[0] <= PW'(l_in) * PW'(gain[0]);
      prod_r[1] <= PW'(l_in) * PW'(gain[1]);
      prod_r[2] <= PW'(r_in) * PW'(gain[2]);
      prod_r[3] <= PW'(r_in) * PW'(gain[3]);
    end
  end

  always_comb begin
    sum_l     = SW'(prod_r[0]) + SW'(prod_r[2]) + HALF_S;
    sum_r     = SW'(prod_r[1]) + SW'(prod_r[3]) + HALF_S;
    out_l_nxt = sat($signed(sum_l[SW-1:GF]));
    out_r_nxt = sat($signed(sum_r[SW-1:GF]));
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      out_l_r <= out_l_nxt;
      out_r_r <= out_r_nxt;
    end
  end

  assign left_out  = out_l_r;
  assign right_out = out_r_r;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stereo_width_panner_core. A short directed table
// (field extremes, hard left/right, wide and over-wide spread, mono and
// silence) is followed by random sample pairs. Every accepted request is
// predicted in fixed point and queued, and each result is checked field by
// field against the oldest prediction. Both sides idle at random, with
// burst stretches, one long output hold-off and two full drains mid-run.
// ----------------------------------------------------------------------------

module testbench;

  localparam int SB  = swp_pkg::SAMPLE_BITS_DEF;
  localparam int AB  = swp_pkg::ANGLE_BITS_DEF;
  localparam int TD  = swp_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int SPW = swp_pkg::SPREAD_BITS;

  localparam longint unsigned QUARTER  = 64'd1 << (AB - 2);
  localparam longint          GAIN_ONE = 64'sd1 <<< swp_pkg::GAIN_FRAC;
  localparam longint          HALF_LSB = GAIN_ONE / 2;
  localparam longint          SAT_MAX  = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint          SAT_MIN  = -SAT_MAX - 1;

  localparam int RANDOM_PAIRS = 1700;
  localparam int DRAIN_AT     = 900;   // sender waits for every result here
  localparam int BURST_LO     = 300;   // sender offers back to back in this band
  localparam int BURST_HI     = 500;
  localparam int HOLD_AT      = 400;   // receiver stalls long after this many results
  localparam int HOLD_CYCLES  = 80;
  localparam int SINK_FAST_LO = 700;   // receiver never stalls in this band
  localparam int SINK_FAST_HI = 900;
  localparam int TAIL_CYCLES  = 12;    // pipeline is seven deep

  localparam logic signed [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_ZERO = '0;
  localparam logic signed [SB-1:0] S_HALF = {2'b01, {(SB-2){1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0]     left_s;
    logic signed [SB-1:0]     right_s;
    logic [AB-1:0]            azimuth;
    logic [SPW-1:0]           spread;
  } pair_req_t;

  typedef struct packed {
    logic signed [SB-1:0] left_s;
    logic signed [SB-1:0] right_s;
  } panned_t;

  // directed row: request, plus a hand-written result where it is obvious
  typedef struct packed {
    pair_req_t rq;
    logic      typed;
    panned_t   want;
  } dir_row_t;

  localparam panned_t SILENCE = '{S_ZERO, S_ZERO};

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // silence in gives silence out, whatever the angle and width
    '{'{S_ZERO, S_ZERO, 12'd0,    11'd0},    1'b1, SILENCE},
    '{'{S_ZERO, S_ZERO, 12'd4095, 11'd2047}, 1'b1, SILENCE},
    '{'{S_ZERO, S_ZERO, 12'd1024, 11'd1024}, 1'b1, SILENCE},
    // full-scale at centre
    '{'{S_MAX,  S_MAX,  12'd0,    11'd0},    1'b0, SILENCE},
    '{'{S_MIN,  S_MIN,  12'd0,    11'd0},    1'b0, SILENCE},
    '{'{S_MAX,  S_MIN,  12'd0,    11'd1024}, 1'b0, SILENCE},
    // hard left / hard right: with no spread both sources sit on one side
    '{'{S_MAX,  S_MAX,  12'd1024, 11'd0},    1'b0, SILENCE},
    '{'{S_MIN,  S_MIN,  12'd1024, 11'd0},    1'b0, SILENCE},
    '{'{S_MAX,  S_MAX,  12'd3072, 11'd0},    1'b0, SILENCE},
    '{'{S_MIN,  S_MIN,  12'd3072, 11'd0},    1'b0, SILENCE},
    '{'{S_MAX,  S_MIN,  12'd1024, 11'd1024}, 1'b0, SILENCE},
    '{'{S_MIN,  S_MAX,  12'd3072, 11'd1024}, 1'b0, SILENCE},
    // spread beyond 100 percent, positions must still clamp
    '{'{S_MAX,  S_MAX,  12'd2048, 11'd2047}, 1'b0, SILENCE},
    '{'{S_MIN,  S_MIN,  12'd512,  11'd1025}, 1'b0, SILENCE},
    '{'{S_MAX,  S_MIN,  12'd4095, 11'd2047}, 1'b0, SILENCE},
    // tiny values, a one-step angle and a small one
    '{'{24'sd1, -24'sd1, 12'd1,   11'd1},    1'b0, SILENCE},
    '{'{-24'sd1, 24'sd1, 12'd100, 11'd0},    1'b0, SILENCE},
    // mono source swept round the quadrants
    '{'{S_HALF, S_HALF, 12'd512,  11'd512},  1'b0, SILENCE},
    '{'{S_HALF, S_HALF, 12'd1536, 11'd512},  1'b0, SILENCE},
    '{'{S_HALF, S_HALF, 12'd2560, 11'd512},  1'b0, SILENCE},
    '{'{S_HALF, S_HALF, 12'd3584, 11'd512},  1'b0, SILENCE},
    '{'{S_HALF, S_HALF, 12'd2047, 11'd256},  1'b0, SILENCE}
  };

  logic clk = 1'b0;
  logic rst_n;

  swp_in_if  in_ch ();
  swp_out_if out_ch ();

  stereo_width_panner_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predicted results, oldest first
  panned_t panned_q [$];
  int      mismatches   = 0;
  int      results_seen = 0;

  // quarter-wave sine, Q.23
  longint sine_lut [0:TD];

  // --------------------------------------------------------------------------
  // Sine table: Taylor series in Q.30 up to x^13, rounded to Q.23
  // --------------------------------------------------------------------------
  initial begin : sine_lut_build
    longint unsigned x, x2, term;
    longint          sum, v;
    for (int i = 0; i <= TD; i++) begin
      x    = swp_pkg::HALF_PI_Q30 * longint'(i) / longint'(TD);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 64) >>> 7;
      if (v > GAIN_ONE) v = GAIN_ONE;
      sine_lut[i] = v;
    end
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint sine_at(input longint unsigned phase);
    longint unsigned p, quad, r, idx;
    longint          v;
    p    = phase & ((64'd1 << AB) - 1);
    quad = (p >> (AB - 2)) & 64'd3;
    r    = p & (QUARTER - 1);
    if (quad[0]) r = QUARTER - r;   // odd quadrants run the table backwards
    idx  = r * longint'(TD) / QUARTER;
    if (idx > TD) idx = TD;
    v    = sine_lut[idx];
    return quad[1] ? -v : v;        // lower half-turn is negated
  endfunction

  // half-up rounding of v / 2^23; arithmetic shift floors negatives
  function automatic longint round_q23(input longint v);
    return (v + HALF_LSB) >>> swp_pkg::GAIN_FRAC;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v < -GAIN_ONE) return -GAIN_ONE;
    if (v > GAIN_ONE)  return GAIN_ONE;
    return v;
  endfunction

  // position in [-1, 1] to an angle in [0, quarter turn]
  function automatic longint unsigned pos_angle(input longint pos);
    longint unsigned u;
    u = longint'(pos + GAIN_ONE);
    return (u * QUARTER + longint'(GAIN_ONE)) >> (swp_pkg::GAIN_FRAC + 1);
  endfunction

  function automatic logic signed [SB-1:0] saturate(input longint v);
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    return v[SB-1:0];
  endfunction

  function automatic panned_t pan_pair(input pair_req_t rq);
    longint          l, r, pan, w, pl, pr, apan, curve, comp;
    longint          gll, glr, grl, grr;
    longint unsigned phl, phr, comp_angle;
    panned_t         res;
    l   = rq.left_s;
    r   = rq.right_s;
    pan = -sine_at(longint'(rq.azimuth));
    w   = longint'(rq.spread) <<< swp_pkg::SPREAD_SHIFT;

    pl  = clamp_unit(pan - w);
    pr  = clamp_unit(pan + w);
    phl = pos_angle(pl);
    phr = pos_angle(pr);

    // centre compensation: full depth at the middle, none at the sides
    apan       = (pan < 0) ? -pan : pan;
    comp_angle = (longint'(apan) * QUARTER + longint'(HALF_LSB)) >> swp_pkg::GAIN_FRAC;
    curve      = sine_at(comp_angle + QUARTER);
    comp       = GAIN_ONE - round_q23(longint'(swp_pkg::COMP_DEPTH) * curve);

    gll = round_q23(sine_at(phl + QUARTER) * comp);
    glr = round_q23(sine_at(phl) * comp);
    grl = round_q23(sine_at(phr + QUARTER) * comp);
    grr = round_q23(sine_at(phr) * comp);

    res.left_s  = saturate(round_q23(l * gll + r * grl));
    res.right_s = saturate(round_q23(l * glr + r * grr));
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [SB-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return S_ZERO;
      3:       return SB'($urandom_range(0, 15) - 8);   // around zero
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic pair_req_t random_pair();
    pair_req_t rq;
    rq.left_s  = random_sample();
    rq.right_s = ($urandom_range(0, 3) == 0) ? rq.left_s : random_sample();
    case ($urandom_range(0, 9))
      0:       rq.azimuth = AB'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 2) - 1);
      default: rq.azimuth = AB'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       rq.spread = SPW'($urandom_range(1025, 2047));
      1:       rq.spread = $urandom_range(0, 1) ? 11'd1024 : 11'd0;
      default: rq.spread = SPW'($urandom_range(0, 1024));
    endcase
    return rq;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender: idles for the given gap, then holds the request until it is taken.
  // The prediction is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic offer_pair(input pair_req_t rq, input logic typed,
                            input panned_t want, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= rq.left_s;
    in_ch.right_in <= rq.right_s;
    in_ch.azimuth  <= rq.azimuth;
    in_ch.spread   <= rq.spread;
    do @(posedge clk); while (!in_ch.ready);
    panned_q.insert(panned_q.size(), typed ? want : pan_pair(rq));
  endtask

  // stop offering until every outstanding request has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (panned_q.size() != 0);
  endtask

  initial begin : sender
    int gap;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    in_ch.azimuth  <= '0;
    in_ch.spread   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      gap = (i < 6) ? 0 : $urandom_range(0, 4);
      offer_pair(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].want, gap);
    end
    drain_results();

    // random part, with a burst band and one full drain
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == DRAIN_AT) drain_results();
      gap = (n >= BURST_LO && n < BURST_HI) ? 0 : $urandom_range(0, 4);
      offer_pair(random_pair(), 1'b0, SILENCE, gap);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (panned_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", panned_q.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls per result, one long hold-off while the sender
  // keeps pushing (fills the pipe, back-pressures the input), and a no-stall
  // band. Each taken result is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int      stall;
    panned_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      else if (results_seen >= SINK_FAST_LO && results_seen < SINK_FAST_HI) stall = 0;
      else stall = $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (panned_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d",
                                  out_ch.left_out, out_ch.right_out));
      end else begin
        want = panned_q.pop_front();
        if (out_ch.left_out !== want.left_s)
          report_mismatch($sformatf("result %0d left_out %0d, want %0d",
                                    results_seen, out_ch.left_out, want.left_s));
        if (out_ch.right_out !== want.right_s)
          report_mismatch($sformatf("result %0d right_out %0d, want %0d",
                                    results_seen, out_ch.right_out, want.right_s));
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
